### hw/rtl/imu_pkg.sv
// Shared types and constants for the IMU serial frame decoder.
// Used by imu_frame_collect, imu_frame_scale and the top level; no dependencies.
package imu_pkg;

   localparam int FRAME_LENGTH = 11;
   localparam int BUF_DEPTH    = FRAME_LENGTH - 1;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_ACCEL  = 8'h51;
   localparam logic [7:0] TYPE_RATE   = 8'h52;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;

   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2
   } imu_kind_type;

   // Raw contents of one complete frame, ready for scaling
   typedef struct packed {
      imu_kind_type       kind;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
      logic signed [15:0] raw_t;
   } imu_frame_type;

endpackage

### hw/rtl/imu_serial_frame_decoder.sv
// Top level of the IMU serial frame decoder: byte collector followed by the scaling stage.
// Depends on imu_pkg, imu_frame_collect and imu_frame_scale.
//
//   channel   handshake             payload
//   req       req_valid/req_ready   req_rx_byte[7:0]
//   rsp       rsp_valid/rsp_ready   rsp_packet_kind, rsp_axis_x/y/z, rsp_temperature
//
// One byte is taken every cycle while req_ready is high; the checksum byte of a known frame
// type yields a result through the frame register, then the result register.
// Reset clears the byte count and both valid flags; the frame buffer is not cleared.
// A stalled result holds in the result register while a second frame waits in the
// frame register; bytes keep flowing until that frame register is also occupied.
module imu_serial_frame_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_packet_kind,
   output logic signed [19:0] rsp_axis_x,
   output logic signed [19:0] rsp_axis_y,
   output logic signed [19:0] rsp_axis_z,
   output logic signed [16:0] rsp_temperature
);
   import imu_pkg::*;

   logic          frame_valid;
   logic          frame_ready;
   imu_frame_type frame;

   imu_frame_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready)
   );

   imu_frame_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .frame_valid     (frame_valid),
      .frame           (frame),
      .frame_ready     (frame_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_kind (rsp_packet_kind),
      .rsp_axis_x      (rsp_axis_x),
      .rsp_axis_y      (rsp_axis_y),
      .rsp_axis_z      (rsp_axis_z),
      .rsp_temperature (rsp_temperature)
   );

endmodule

### hw/rtl/imu_frame_collect.sv
// Byte collector: hunts for the header, buffers a frame and registers its raw words.
// Depends on imu_pkg.
module imu_frame_collect (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   frame_valid,
   output imu_pkg::imu_frame_type frame,
   input  logic                   frame_ready
);
   import imu_pkg::*;

   localparam logic [3:0] LAST_INDEX = 4'(FRAME_LENGTH - 1);

   logic [3:0]    byte_count_ff, byte_count_in;
   logic [7:0]    frame_buf_ff [BUF_DEPTH];
   logic          frame_valid_ff, frame_valid_in;
   imu_frame_type frame_ff, frame_in;
   logic          accept;
   logic          is_last;
   logic          drop_byte;
   logic          store_byte;
   logic          kind_known;
   imu_kind_type  kind;

   assign req_ready   = !frame_valid_ff || frame_ready;
   assign accept      = req_valid && req_ready;
   assign is_last     = (byte_count_ff == LAST_INDEX);
   assign drop_byte   = (byte_count_ff == 4'd0) && (req_rx_byte != HEADER_BYTE);
   assign store_byte  = accept && !drop_byte && !is_last;
   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

   always_comb begin
      case (frame_buf_ff[1])
         TYPE_ACCEL: begin
            kind       = KIND_ACCEL;
            kind_known = 1'b1;
         end
         TYPE_RATE: begin
            kind       = KIND_RATE;
            kind_known = 1'b1;
         end
         TYPE_ANGLE: begin
            kind       = KIND_ANGLE;
            kind_known = 1'b1;
         end
         default: begin
            kind       = KIND_ACCEL;
            kind_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      frame_in.kind  = kind;
      frame_in.raw_x = {frame_buf_ff[3], frame_buf_ff[2]};
      frame_in.raw_y = {frame_buf_ff[5], frame_buf_ff[4]};
      frame_in.raw_z = {frame_buf_ff[7], frame_buf_ff[6]};
      frame_in.raw_t = {frame_buf_ff[9], frame_buf_ff[8]};
   end

   always_comb begin
      byte_count_in  = byte_count_ff;
      frame_valid_in = frame_valid_ff && !frame_ready;
      if (accept && !drop_byte) begin
         if (is_last) begin
            // checksum byte closes the frame; unknown types are dropped
            byte_count_in  = 4'd0;
            frame_valid_in = frame_valid_in || kind_known;
         end else begin
            byte_count_in = byte_count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 4'd0;
         frame_valid_ff <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         frame_buf_ff[byte_count_ff] <= req_rx_byte;
      end
      if (accept && !drop_byte && is_last) begin
         frame_ff <= frame_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= LAST_INDEX)
      else $error("byte count beyond frame length");

   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      frame_valid_ff && !frame_ready |=> frame_valid_ff && $stable(frame_ff))
      else $error("stalled frame lost or changed");

   a_hunt_drop: assert property (@(posedge clock) disable iff (reset)
      accept && drop_byte |=> byte_count_ff == 4'd0)
      else $error("non-header byte started a frame");

   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> byte_count_ff == 4'd0)
      else $error("count did not wrap after checksum byte");
`endif

endmodule

### hw/rtl/imu_frame_scale.sv
// Scaling stage: converts raw frame words to Q8 values and holds the result register.
// Depends on imu_pkg.
module imu_frame_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     frame_valid,
   input  imu_pkg::imu_frame_type   frame,
   output logic                     frame_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_packet_kind,
   output logic signed [19:0]       rsp_axis_x,
   output logic signed [19:0]       rsp_axis_y,
   output logic signed [19:0]       rsp_axis_z,
   output logic signed [16:0]       rsp_temperature
);
   import imu_pkg::*;

   // floor(t*64/85): bias the numerator positive, then multiply by a rounded-up
   // reciprocal; the reciprocal error times the largest numerator stays below 2^30
   localparam int TEMP_DIV    = 85;
   localparam int TEMP_K      = 24673;
   localparam int TEMP_BIAS   = TEMP_DIV * TEMP_K;
   localparam int TEMP_SHIFT  = 30;
   localparam int TEMP_RECIP  = ((1 << TEMP_SHIFT) + TEMP_DIV - 1) / TEMP_DIV;
   localparam int TEMP_OFFSET = 9280;
   localparam int TEMP_ADJ    = TEMP_K - TEMP_OFFSET;

   function automatic logic signed [19:0] scale_axis(imu_kind_type kind,
                                                     logic signed [15:0] raw);
      logic signed [22:0] rate_prod;
      logic signed [21:0] angle_prod;
      logic signed [19:0] res;
      rate_prod  = 23'(raw) * 23'sd125;
      angle_prod = 22'(raw) * 22'sd45;
      case (kind)
         KIND_ACCEL: res = 20'(raw >>> 3);
         KIND_RATE:  res = 20'(rate_prod >>> 3);
         KIND_ANGLE: res = 20'(angle_prod >>> 5);
         default:    res = '0;
      endcase
      return res;
   endfunction

   logic               rsp_valid_ff;
   logic [1:0]         kind_ff;
   logic signed [19:0] axis_x_ff, axis_y_ff, axis_z_ff;
   logic signed [16:0] temp_ff, temp_in;
   logic [23:0]        temp_biased;
   logic [22:0]        temp_num;
   logic [46:0]        temp_prod;
   logic [16:0]        temp_quot;
   logic               load;

   assign frame_ready = !rsp_valid_ff || rsp_ready;
   assign load        = frame_valid && frame_ready;

   always_comb begin
      temp_biased = {{2{frame.raw_t[15]}}, frame.raw_t, 6'b0} + 24'(TEMP_BIAS);
      temp_num    = temp_biased[22:0];
      temp_prod   = 47'(temp_num) * 47'(TEMP_RECIP);
      temp_quot   = temp_prod[46:TEMP_SHIFT];
      temp_in     = 17'(temp_quot - 17'(TEMP_ADJ));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_ready) begin
         rsp_valid_ff <= frame_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= 2'(frame.kind);
         axis_x_ff <= scale_axis(frame.kind, frame.raw_x);
         axis_y_ff <= scale_axis(frame.kind, frame.raw_y);
         axis_z_ff <= scale_axis(frame.kind, frame.raw_z);
         temp_ff   <= temp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_kind = kind_ff;
   assign rsp_axis_x      = axis_x_ff;
   assign rsp_axis_y      = axis_y_ff;
   assign rsp_axis_z      = axis_z_ff;
   assign rsp_temperature = temp_ff;

`ifndef SYNTHESIS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded frame did not reach the result register");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> temp_ff >= -17'sd15393 && temp_ff <= 17'sd33951)
      else $error("temperature out of range");

   a_accel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_ACCEL |->
         axis_x_ff >= -20'sd4096 && axis_x_ff <= 20'sd4095)
      else $error("acceleration value out of range");
`endif

endmodule

### tb/tb_imu_serial_frame_decoder.sv
// Self-checking testbench for imu_serial_frame_decoder: drives serial bytes, predicts the
// decoded reports from its own frame model and checks each response field by field.
// Depends on imu_pkg and the imu_serial_frame_decoder RTL.
module tb_imu_serial_frame_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import imu_pkg::*;

   localparam int RUN_LIMIT_NS = 5_000_000;
   localparam int RANDOM_BYTES = 2000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      imu_kind_type       kind;
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic signed [19:0] z;
      logic signed [16:0] temp;
   } imu_report_type;

   // Frame model: collects bytes like the sensor link and queues the reports they cause
   class imu_report_tracker_type;
      logic [3:0]     byte_count;
      logic [7:0]     frame_buf[BUF_DEPTH];
      imu_report_type expected_reports[$];
      int             errors;
      int             frames_seen;
      int             unknown_frames;
      int             dropped_bytes;
      int             reports_checked;

      function new();
         byte_count      = '0;
         errors          = 0;
         frames_seen     = 0;
         unknown_frames  = 0;
         dropped_bytes   = 0;
         reports_checked = 0;
      endfunction

      function logic signed [15:0] word_at(int pos);
         return {frame_buf[pos+1], frame_buf[pos]};
      endfunction

      function logic signed [19:0] scale_axis(imu_kind_type k, logic signed [15:0] raw);
         longint v;
         v = raw;
         case (k)
            KIND_ACCEL: v = v >>> 3;
            KIND_RATE:  v = (v * 125) >>> 3;
            default:    v = (v * 45) >>> 5;
         endcase
         return v[19:0];
      endfunction

      function logic signed [16:0] scale_temp(logic signed [15:0] raw);
         longint n;
         longint q;
         n = raw;
         n = n * 64;
         q = n / 85;
         // floor, not truncation, for negative readings
         if ((n % 85) != 0 && n < 0) q = q - 1;
         q = q + 9280;
         return q[16:0];
      endfunction

      function void take_byte(logic [7:0] b);
         imu_report_type rep;
         if (byte_count == 0 && b != HEADER_BYTE) begin
            dropped_bytes++;
            return;
         end
         if (byte_count < BUF_DEPTH) begin
            frame_buf[byte_count] = b;
            byte_count++;
            return;
         end
         // checksum byte closes the frame and is never checked
         byte_count = '0;
         frames_seen++;
         case (frame_buf[1])
            TYPE_ACCEL: rep.kind = KIND_ACCEL;
            TYPE_RATE:  rep.kind = KIND_RATE;
            TYPE_ANGLE: rep.kind = KIND_ANGLE;
            default: begin
               unknown_frames++;
               return;
            end
         endcase
         rep.x    = scale_axis(rep.kind, word_at(2));
         rep.y    = scale_axis(rep.kind, word_at(4));
         rep.z    = scale_axis(rep.kind, word_at(6));
         rep.temp = scale_temp(word_at(8));
         expected_reports.push_back(rep);
      endfunction

      function void check_result(logic [1:0] kind, logic signed [19:0] x,
                                 logic signed [19:0] y, logic signed [19:0] z,
                                 logic signed [16:0] temp);
         imu_report_type exp_rep;
         if (expected_reports.size() == 0) begin
            $error("unexpected response: kind %0d x %0d y %0d z %0d temperature %0d",
                   kind, x, y, z, temp);
            errors++;
            return;
         end
         exp_rep = expected_reports.pop_front();
         reports_checked++;
         if (kind !== exp_rep.kind) begin
            $error("packet_kind expected %0d actual %0d", exp_rep.kind, kind);
            errors++;
         end
         if (x !== exp_rep.x) begin
            $error("axis_x expected %0d actual %0d", exp_rep.x, x);
            errors++;
         end
         if (y !== exp_rep.y) begin
            $error("axis_y expected %0d actual %0d", exp_rep.y, y);
            errors++;
         end
         if (z !== exp_rep.z) begin
            $error("axis_z expected %0d actual %0d", exp_rep.z, z);
            errors++;
         end
         if (temp !== exp_rep.temp) begin
            $error("temperature expected %0d actual %0d", exp_rep.temp, temp);
            errors++;
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_packet_kind;
   logic signed [19:0] rsp_axis_x;
   logic signed [19:0] rsp_axis_y;
   logic signed [19:0] rsp_axis_z;
   logic signed [16:0] rsp_temperature;

   imu_report_tracker_type tracker = new();

   bit gaps_on;
   bit hold_request;
   int burst_left;
   int bytes_sent;

   imu_serial_frame_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_kind (rsp_packet_kind),
      .rsp_axis_x      (rsp_axis_x),
      .rsp_axis_y      (rsp_axis_y),
      .rsp_axis_z      (rsp_axis_z),
      .rsp_temperature (rsp_temperature)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_packet_kind, rsp_axis_x, rsp_axis_y, rsp_axis_z,
                              rsp_temperature);
   end

   // Response side: stall modes picked at random, plus a long hold-off
   initial begin
      int hold_left;
      int mode;
      int mode_left;
      int phase;
      hold_left = 0;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= $urandom_range(0, 1);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((phase % 7) < 3);
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(b);
      bytes_sent++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 8);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input logic [15:0] t, input logic [7:0] csum);
      logic [7:0] bytes[FRAME_LENGTH];
      bytes = '{HEADER_BYTE, kind_byte, x[7:0], x[15:8], y[7:0], y[15:8],
                z[7:0], z[15:8], t[7:0], t[15:8], csum};
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // Drop valid and hold until every queued report has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_known_frame();
      logic [7:0] kind_byte;
      kind_byte = TYPE_ACCEL + 8'($urandom_range(0, 2));
      send_frame(kind_byte, rand_word(), rand_word(), rand_word(), rand_word(),
                 8'($urandom));
   endtask

   task automatic send_random_mix(input int byte_target);
      logic [7:0] b;
      int         pick;
      int         n;
      while (bytes_sent < byte_target) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
         if (pick < 75) begin
            send_known_frame();
         end else if (pick < 85) begin
            do b = 8'($urandom);
            while (b == TYPE_ACCEL || b == TYPE_RATE || b == TYPE_ANGLE);
            send_frame(b, rand_word(), rand_word(), rand_word(), rand_word(),
                       8'($urandom));
         end else if (pick < 93) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom));
         end else begin
            // cut a frame short; the next header becomes data and alignment drifts
            send_byte(HEADER_BYTE);
            n = $urandom_range(1, 9);
            repeat (n) send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = '0;
      rsp_ready    = 1'b0;
      gaps_on      = 1'b0;
      hold_request = 1'b0;
      burst_left   = 1;
      bytes_sent   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: junk before a header, every kind at the extremes, header bytes as data,
      // an unknown type, then a frame to show the count went back to zero
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 8'h00);
      send_frame(TYPE_RATE,  16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 8'hFF);
      send_frame(TYPE_ANGLE, 16'h5555, 16'h0001, 16'h8000, 16'hFFFF, HEADER_BYTE);
      send_frame(8'h54,      16'h1234, 16'h8000, 16'h7FFF, 16'h0000, 8'h00);
      send_frame(TYPE_ACCEL, 16'hFFF9, 16'h0007, 16'h5555, 16'h0055, 8'h55);
      wait_drained();

      gaps_on = 1'b1;
      send_random_mix(bytes_sent + RANDOM_BYTES / 2);

      // back-pressure: responses held off while bytes keep coming with no gaps
      gaps_on      = 1'b0;
      hold_request = 1'b1;
      repeat (8) send_known_frame();
      wait_drained();

      gaps_on = 1'b1;
      send_random_mix(bytes_sent + RANDOM_BYTES / 2);
      wait_drained();

      $display("Sent %0d bytes: %0d frames closed, %0d of unknown type, %0d bytes dropped",
               bytes_sent, tracker.frames_seen, tracker.unknown_frames,
               tracker.dropped_bytes);
      $display("Checked %0d decoded reports, %0d mismatches",
               tracker.reports_checked, tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
